// ===== rtl/mono_framebuffer_pixel_engine_unit_macros.svh =====
// Assertion macros used by the pixel engine sequencer.
`ifndef MONO_FRAMEBUFFER_PIXEL_ENGINE_UNIT_MACROS_SVH
`define MONO_FRAMEBUFFER_PIXEL_ENGINE_UNIT_MACROS_SVH

// The enclosing module must provide clk_i and rst_ni.
`define MFPE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define MFPE_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mfpe_pkg.sv =====
// Package with types, constants and codes of the pixel engine.
package mfpe_pkg;

  localparam int unsigned VRAM_BYTES_DEF = 32768;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DW    = 15;

  localparam int unsigned LIT_W   = 15;
  localparam int unsigned OFF_W   = 22;
  localparam int unsigned PROD_W  = 18;
  localparam int unsigned SPAN_W  = 18;
  localparam int unsigned ZST_W   = 19;
  localparam int unsigned STEP_W  = 11;
  localparam int unsigned ZCNT_W  = 16;

  localparam logic [LIT_W-1:0] LIT_MAX = 15'h7FFF;
  localparam logic [7:0]       PIX_MSB = 8'h80;

  localparam logic [14:0] RST_FPO        = 15'd0;
  localparam logic [7:0]  RST_STRIDE     = 8'd100;
  localparam logic [3:0]  RST_HEIGHT     = 4'd1;
  localparam logic [9:0]  RST_ROWS       = 10'd600;
  localparam logic [10:0] RST_WIDTH      = 11'd800;
  localparam logic [9:0]  RST_VIS_LINES  = 10'd600;

  typedef enum logic [1:0] {
    FN_SET    = 2'd0,
    FN_GET    = 2'd1,
    FN_SCROLL = 2'd2,
    FN_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FPO       = 3'd0,
    CFG_STRIDE    = 3'd1,
    CFG_HEIGHT    = 3'd2,
    CFG_ROWS      = 3'd3,
    CFG_WIDTH     = 3'd4,
    CFG_VIS_LINES = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [14:0] fpo;
    logic [7:0]  stride;
    logic [3:0]  height;
    logic [9:0]  rows_scaled;
    logic [10:0] width;
    logic [9:0]  vis_lines;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_MUL,
    ST_ADDR,
    ST_READ,
    ST_WAIT,
    ST_PWR,
    ST_SPREP,
    ST_STEPGO,
    ST_ZERO,
    ST_STEP,
    ST_RESP
  } state_e;

endpackage

// ===== rtl/mfpe_if.sv =====
// Request and result channel interfaces of the pixel engine.
interface mfpe_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [10:0]       pos_x;
  logic [9:0]        pos_y;
  logic              pixel_value;
  logic signed [7:0] scroll_rows;

  modport source (output valid, func, pos_x, pos_y, pixel_value, scroll_rows, input ready);
  modport sink (input valid, func, pos_x, pos_y, pixel_value, scroll_rows, output ready);
endinterface

interface mfpe_rsp_if;
  logic        valid;
  logic        ready;
  logic        pixel_read;
  logic [14:0] base_now;
  logic [14:0] lit_offset_now;

  modport source (output valid, pixel_read, base_now, lit_offset_now, input ready);
  modport sink (input valid, pixel_read, base_now, lit_offset_now, output ready);
endinterface

// ===== rtl/mfpe_cfg.sv =====
// Configuration register bank of the pixel engine.
module mfpe_cfg import mfpe_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0]    cfg_wdata_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FPO:       cfg_d.fpo         = cfg_wdata_i[14:0];
        CFG_STRIDE:    cfg_d.stride      = cfg_wdata_i[7:0];
        CFG_HEIGHT:    cfg_d.height      = cfg_wdata_i[3:0];
        CFG_ROWS:      cfg_d.rows_scaled = cfg_wdata_i[9:0];
        CFG_WIDTH:     cfg_d.width       = cfg_wdata_i[10:0];
        CFG_VIS_LINES: cfg_d.vis_lines   = cfg_wdata_i[9:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fpo         <= RST_FPO;
      cfg_q.stride      <= RST_STRIDE;
      cfg_q.height      <= RST_HEIGHT;
      cfg_q.rows_scaled <= RST_ROWS;
      cfg_q.width       <= RST_WIDTH;
      cfg_q.vis_lines   <= RST_VIS_LINES;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/mfpe_vram.sv =====
// Single-port frame memory with a registered read port.
module mfpe_vram import mfpe_pkg::*; #(
  parameter int unsigned VRAM_BYTES = VRAM_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(VRAM_BYTES)-1:0] addr_i,
  input  logic [7:0]                    wdata_i,
  output logic [7:0]                    rdata_o
);

  localparam int unsigned AW = $clog2(VRAM_BYTES);

  logic [7:0] mem [2**AW];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mfpe_seq.sv =====
// Command sequencer: pixel reads and read-modify-writes, scroll and clear sweeps.
`include "mono_framebuffer_pixel_engine_unit_macros.svh"
module mfpe_seq import mfpe_pkg::*; #(
  parameter int unsigned VRAM_BYTES = VRAM_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfg_t                          cfg_i,
  mfpe_req_if.sink                      req_i,
  mfpe_rsp_if.source                    rsp_o,
  output logic                          mem_we_o,
  output logic [$clog2(VRAM_BYTES)-1:0] mem_addr_o,
  output logic [7:0]                    mem_wdata_o,
  input  logic [7:0]                    mem_rdata_i
);

  localparam int unsigned AW = $clog2(VRAM_BYTES);

  state_e             state_q, state_d;
  logic [AW-1:0]      base_q, base_d;
  logic [LIT_W-1:0]   lit_q, lit_d;
  logic [AW-1:0]      addr_q, addr_d;
  logic               rsp_valid_q, rsp_valid_d;

  func_e              op_q, op_d;
  logic [10:0]        x_q, x_d;
  logic [9:0]         y_q, y_d;
  logic               pix_q, pix_d;
  logic [7:0]         rows_q, rows_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [OFF_W-1:0]   off_q, off_d;
  logic [7:0]         nb_q, nb_d;
  logic [3:0]         pcnt_q, pcnt_d;
  logic [STEP_W-1:0]  steps_q, steps_d;
  logic [SPAN_W-1:0]  span_q, span_d;
  logic [ZCNT_W-1:0]  zcnt_q, zcnt_d;
  logic               dir_up_q, dir_up_d;
  logic               pixel_q, pixel_d;
  logic               rsp_pixel_q, rsp_pixel_d;
  logic [14:0]        rsp_base_q, rsp_base_d;
  logic [LIT_W-1:0]   rsp_lit_q, rsp_lit_d;

  logic               req_fire;
  logic               in_range;
  logic               rsp_free;
  logic [7:0]         rows_mag;
  logic [11:0]        steps_full;
  logic [9:0]         last_line;
  logic [SPAN_W-1:0]  span_full;
  logic [OFF_W-1:0]   scaled;
  logic [OFF_W-1:0]   pix_off;
  logic [7:0]         pix_mask;
  logic [7:0]         new_byte;
  logic [LIT_W-1:0]   lit_cand;
  logic [AW-1:0]      stride_aw;
  logic [LIT_W:0]     lit_sum;
  logic [LIT_W-1:0]   lit_sat;
  logic [LIT_W-1:0]   lit_clamp;
  logic [ZCNT_W-1:0]  clear_cnt;
  logic [AW-1:0]      up_start;
  logic [AW-1:0]      down_start;
  logic [AW-1:0]      pix_addr;

  assign req_fire   = req_i.valid && req_i.ready;
  assign in_range   = (req_i.pos_y < cfg_i.rows_scaled) && (req_i.pos_x < cfg_i.width);
  assign rsp_free   = !rsp_valid_q || rsp_o.ready;
  assign rows_mag   = rows_q[7] ? (~rows_q + 8'd1) : rows_q;
  assign steps_full = 12'(rows_mag) * 12'(cfg_i.height);
  assign last_line  = cfg_i.vis_lines - 10'd1;
  assign span_full  = SPAN_W'(last_line) * SPAN_W'(cfg_i.stride);
  assign scaled     = OFF_W'(prod_q) * OFF_W'(cfg_i.height);
  assign pix_off    = OFF_W'(cfg_i.fpo) + scaled + OFF_W'(x_q[10:3]);
  assign pix_mask   = PIX_MSB >> x_q[2:0];
  assign new_byte   = pix_q ? (mem_rdata_i | pix_mask) : (mem_rdata_i & ~pix_mask);
  assign lit_cand   = (off_q > OFF_W'(LIT_MAX)) ? LIT_MAX : off_q[LIT_W-1:0];
  assign stride_aw  = AW'(cfg_i.stride);
  assign lit_sum    = {1'b0, lit_q} + (LIT_W+1)'(cfg_i.stride);
  assign lit_sat    = (lit_sum > (LIT_W+1)'(LIT_MAX)) ? LIT_MAX : lit_sum[LIT_W-1:0];
  assign lit_clamp  = ((span_q != '0) && (SPAN_W'(lit_sat) > (span_q - SPAN_W'(1))))
                      ? LIT_W'(span_q - SPAN_W'(1)) : lit_sat;
  assign clear_cnt  = (ZCNT_W'(lit_q) | ZCNT_W'(1)) + ZCNT_W'(1);
  assign up_start   = base_q + AW'(cfg_i.fpo);
  assign down_start = base_q + AW'(ZST_W'(cfg_i.fpo) + ZST_W'(span_q));
  assign pix_addr   = base_q + off_q[AW-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (addr_q == {AW{1'b1}}) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_fire) begin
          case (req_i.func)
            FN_SET, FN_GET: state_d = in_range ? ST_MUL : ST_RESP;
            FN_SCROLL:      state_d = ST_SPREP;
            default:        state_d = ST_ZERO;
          endcase
        end
      end
      ST_MUL:  state_d = ST_ADDR;
      ST_ADDR: state_d = ST_READ;
      ST_READ: state_d = ST_WAIT;
      ST_WAIT: begin
        state_d = (op_q == FN_SET && cfg_i.height != 4'd0) ? ST_PWR : ST_RESP;
      end
      ST_PWR: begin
        if (pcnt_q == 4'd1) begin
          state_d = ST_RESP;
        end
      end
      ST_SPREP: state_d = ST_STEPGO;
      ST_STEPGO: begin
        if (steps_q == '0) begin
          state_d = ST_RESP;
        end else if (cfg_i.stride == 8'd0) begin
          state_d = ST_STEP;
        end else begin
          state_d = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (zcnt_q == ZCNT_W'(1)) begin
          state_d = (op_q == FN_CLEAR) ? ST_RESP : ST_STEP;
        end
      end
      ST_STEP: state_d = ST_STEPGO;
      ST_RESP: begin
        if (rsp_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready = 1'b0;
    mem_we_o    = 1'b0;
    mem_addr_o  = addr_q;
    mem_wdata_o = 8'h00;
    case (state_q)
      ST_IDLE: req_i.ready = 1'b1;
      ST_INIT, ST_ZERO: mem_we_o = 1'b1;
      ST_READ: mem_addr_o = pix_addr;
      ST_PWR: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = nb_q;
      end
      default: mem_we_o = 1'b0;
    endcase
  end

  always_comb begin
    base_d      = base_q;
    lit_d       = lit_q;
    addr_d      = addr_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    op_d        = op_q;
    x_d         = x_q;
    y_d         = y_q;
    pix_d       = pix_q;
    rows_d      = rows_q;
    prod_d      = prod_q;
    off_d       = off_q;
    nb_d        = nb_q;
    pcnt_d      = pcnt_q;
    steps_d     = steps_q;
    span_d      = span_q;
    zcnt_d      = zcnt_q;
    dir_up_d    = dir_up_q;
    pixel_d     = pixel_q;
    rsp_pixel_d = rsp_pixel_q;
    rsp_base_d  = rsp_base_q;
    rsp_lit_d   = rsp_lit_q;
    case (state_q)
      ST_INIT: addr_d = addr_q + AW'(1);
      ST_IDLE: begin
        if (req_fire) begin
          op_d    = func_e'(req_i.func);
          x_d     = req_i.pos_x;
          y_d     = req_i.pos_y;
          pix_d   = req_i.pixel_value;
          rows_d  = req_i.scroll_rows;
          pixel_d = 1'b0;
          zcnt_d  = clear_cnt;
          addr_d  = base_q;
        end
      end
      ST_MUL:  prod_d = PROD_W'(y_q) * PROD_W'(cfg_i.stride);
      ST_ADDR: off_d = pix_off;
      ST_WAIT: begin
        if (op_q == FN_GET) begin
          pixel_d = |(mem_rdata_i & pix_mask);
        end
        nb_d   = new_byte;
        pcnt_d = cfg_i.height;
        addr_d = pix_addr;
      end
      ST_PWR: begin
        addr_d = addr_q + stride_aw;
        off_d  = off_q + OFF_W'(cfg_i.stride);
        pcnt_d = pcnt_q - 4'd1;
        if (nb_q != 8'h00 && lit_cand > lit_q) begin
          lit_d = lit_cand;
        end
      end
      ST_SPREP: begin
        steps_d  = STEP_W'(steps_full);
        span_d   = span_full;
        dir_up_d = !rows_q[7];
      end
      ST_STEPGO: begin
        zcnt_d = ZCNT_W'(cfg_i.stride);
        addr_d = dir_up_q ? up_start : down_start;
      end
      ST_ZERO: begin
        addr_d = addr_q + AW'(1);
        zcnt_d = zcnt_q - ZCNT_W'(1);
        if (zcnt_q == ZCNT_W'(1) && op_q == FN_CLEAR) begin
          lit_d = '0;
        end
      end
      ST_STEP: begin
        steps_d = steps_q - STEP_W'(1);
        if (dir_up_q) begin
          base_d = base_q + stride_aw;
          if (lit_q >= LIT_W'(cfg_i.stride)) begin
            lit_d = lit_q - LIT_W'(cfg_i.stride);
          end
        end else begin
          base_d = base_q - stride_aw;
          lit_d  = lit_clamp;
        end
      end
      ST_RESP: begin
        if (rsp_free) begin
          rsp_valid_d = 1'b1;
          rsp_pixel_d = pixel_q;
          rsp_base_d  = 15'(base_q);
          rsp_lit_d   = lit_q;
        end
      end
      default: addr_d = addr_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      base_q      <= '0;
      lit_q       <= '0;
      addr_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      lit_q       <= lit_d;
      addr_q      <= addr_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    x_q         <= x_d;
    y_q         <= y_d;
    pix_q       <= pix_d;
    rows_q      <= rows_d;
    prod_q      <= prod_d;
    off_q       <= off_d;
    nb_q        <= nb_d;
    pcnt_q      <= pcnt_d;
    steps_q     <= steps_d;
    span_q      <= span_d;
    zcnt_q      <= zcnt_d;
    dir_up_q    <= dir_up_d;
    pixel_q     <= pixel_d;
    rsp_pixel_q <= rsp_pixel_d;
    rsp_base_q  <= rsp_base_d;
    rsp_lit_q   <= rsp_lit_d;
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.pixel_read     = rsp_pixel_q;
  assign rsp_o.base_now       = rsp_base_q;
  assign rsp_o.lit_offset_now = rsp_lit_q;

  `MFPE_ASSERT_IMP(a_init_blocks_req, state_q == ST_INIT, !req_i.ready, "request taken during memory clearing")
  `MFPE_ASSERT_IMP(a_we_only_in_write_states, mem_we_o, (state_q == ST_INIT || state_q == ST_ZERO || state_q == ST_PWR), "memory write outside a write state")
  `MFPE_ASSERT_IMP(a_sweep_writes_zero, mem_we_o && state_q != ST_PWR, mem_wdata_o == 8'h00, "sweep writes nonzero data")
  `MFPE_ASSERT_NXT(a_req_leaves_idle, req_fire, state_q != ST_IDLE, "accepted request did not start work")
  `MFPE_ASSERT_IMP(a_clear_resets_lit, state_q == ST_RESP && op_q == FN_CLEAR, lit_q == '0, "clear left a lit offset")

endmodule

// ===== rtl/mono_framebuffer_pixel_engine_unit.sv =====
// Top level of the one-bit-per-pixel frame memory engine.
// The block takes drawing requests on req_i (set pixel, get pixel, scroll, clear) and
// returns one result on rsp_o per request: the pixel read, the base pointer and the
// highest lit byte offset after the request. Configuration registers are written
// through cfg_we_i, cfg_idx_i and cfg_wdata_i; the user must write them only while no
// request is in progress, which the block does not enforce. After reset the frame
// memory is swept to zero, one byte per cycle, and req_i.ready stays low until the
// sweep ends. VRAM_BYTES must be a power of two; the block does not enforce it.
// The frame data lives in a single-port memory, so one request is worked on at a time.
// A set pixel writes the modified byte once per repeated line, scanline_height times.
// A scroll clears line_stride bytes, one byte per cycle, in each of |scroll_rows| *
// scanline_height steps. A clear zeroes, from the base pointer, the lit offset plus
// one bytes, rounded up to an even count. Out-of-range coordinates skip the memory
// and go straight to the result. The next request is accepted in the cycle after the
// result is loaded. Results wait in an output register while rsp_o.ready is low; the
// next request is still accepted and worked on, but its result is held until the
// register empties.
module mono_framebuffer_pixel_engine_unit import mfpe_pkg::*; #(
  parameter int unsigned VRAM_BYTES = VRAM_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0]    cfg_wdata_i,
  mfpe_req_if.sink             req_i,
  mfpe_rsp_if.source           rsp_o
);

  localparam int unsigned AW = $clog2(VRAM_BYTES);

  cfg_t          cfg;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;

  mfpe_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mfpe_vram #(
    .VRAM_BYTES (VRAM_BYTES)
  ) u_vram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  mfpe_seq #(
    .VRAM_BYTES (VRAM_BYTES)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_we_o    (mem_we),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

endmodule
